/* hw/rtl/dlf_pkg.sv */
package dlf_pkg;

	// Width of a Q8.8 data word.
	localparam int DataW = 16;

	// Configuration register indexes.
	localparam logic [1:0] CFG_N_INPUTS        = 2'd0;
	localparam logic [1:0] CFG_N_OUTPUTS       = 2'd1;
	localparam logic [1:0] CFG_ACTIVATION_MODE = 2'd2;
	localparam logic [1:0] CFG_BIAS            = 2'd3;

	// Item function codes.
	localparam logic FUNC_WEIGHT     = 1'b0;
	localparam logic FUNC_ACTIVATION = 1'b1;

	// Activation modes.
	localparam logic ACT_LINEAR = 1'b0;
	localparam logic ACT_RELU   = 1'b1;

	// Load word: one weight or one activation.
	typedef struct packed {
		logic                    func;
		logic [7:0]              index;
		logic signed [DataW-1:0] value;
		logic                    last;
	} req_word_t;

	// Result word: one output neuron.
	typedef struct packed {
		logic [3:0]              out_index;
		logic signed [DataW-1:0] out_value;
		logic                    out_last;
	} rsp_word_t;

	// Control that travels with one multiply-accumulate step.
	typedef struct packed {
		logic valid;
		logic first;
		logic final_step;
		logic zero;
	} mac_ctrl_t;

endpackage

/* hw/rtl/dlf_mac.sv */
module dlf_mac #(
	parameter int AccW = 38
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  dlf_pkg::mac_ctrl_t                ctrl,
	input  logic signed [dlf_pkg::DataW-1:0]  act,
	input  logic signed [dlf_pkg::DataW-1:0]  wgt,
	input  logic signed [dlf_pkg::DataW-1:0]  bias,
	output logic                              res_valid,
	output logic signed [dlf_pkg::DataW-1:0]  res_value
);
	import dlf_pkg::*;

	localparam int ProdW = 2 * DataW;

	mac_ctrl_t                 ctrl_s2;
	logic signed [ProdW-1:0]   prod_s2;
	logic signed [AccW-1:0]    acc_q;
	logic signed [AccW-1:0]    acc_next;
	logic signed [AccW-1:0]    acc_base;
	logic signed [AccW-1:0]    prod_ext;
	logic signed [AccW-1:0]    sum_s3;
	logic                      valid_s3;
	logic signed [AccW-1:0]    rnd;
	logic signed [AccW-1:0]    shifted;

	// Multiply stage: the product is exact, and forced to zero for an empty row.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s2 <= '0;
		end else begin
			ctrl_s2 <= ctrl;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.zero) begin
			prod_s2 <= '0;
		end else begin
			prod_s2 <= ProdW'(act) * ProdW'(wgt);
		end
	end

	// Accumulate stage: the first step of a row starts from the bias in Q16.16.
	assign acc_base = {{(AccW-DataW-8){bias[DataW-1]}}, bias, 8'b0};
	assign prod_ext = {{(AccW-ProdW){prod_s2[ProdW-1]}}, prod_s2};
	assign acc_next = (ctrl_s2.first ? acc_base : acc_q) + prod_ext;

	always_ff @(posedge clk) begin
		if (ctrl_s2.valid) begin
			acc_q <= acc_next;
		end
		if (ctrl_s2.valid && ctrl_s2.final_step) begin
			sum_s3 <= acc_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= ctrl_s2.valid && ctrl_s2.final_step;
		end
	end

	// Round to Q8.8 with ties upwards, then saturate.
	assign rnd     = sum_s3 + $signed(AccW'(128));
	assign shifted = rnd >>> 8;

	always_comb begin
		if (shifted > $signed(AccW'(32767))) begin
			res_value = 16'sh7FFF;
		end else if (shifted < -$signed(AccW'(32768))) begin
			res_value = -16'sh8000;
		end else begin
			res_value = shifted[DataW-1:0];
		end
	end

	assign res_valid = valid_s3;

endmodule

/* hw/rtl/dense_layer_forward_top.sv */
// Fully connected layer, forward pass, signed Q8.8. Load words write one weight
// (address out*n_inputs+in) or one input activation each, one word per cycle
// while idle. A word with last set starts a run once its own write is done: with
// ReLU mode the stored activations are clamped in place, and for each output
// neuron the block walks the weight row in a memory, one multiply-accumulate per
// cycle, and delivers the bias plus dot product, rounded and saturated. Each step
// passes the memory read registers, the multiply register and the accumulator;
// the row's sum is registered, then rounded and saturated into the result
// register. Outputs come one at a time: the weight memory has a single read port,
// and a row walk starts only once the result register is free, so a result not
// taken holds the next output back. No load word is taken during a run. There is
// no clearing pass after reset; stores must be written before they are used.
module dense_layer_forward_top #(
	parameter int MAX_INPUTS  = 16,
	parameter int MAX_OUTPUTS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_ready,
	input  dlf_pkg::req_word_t           req_word,
	output logic                         rsp_valid,
	input  logic                         rsp_ready,
	output dlf_pkg::rsp_word_t           rsp_word,
	input  logic                         cfg_we,
	input  logic [1:0]                   cfg_index,
	input  logic [15:0]                  cfg_data
);
	import dlf_pkg::*;

	localparam int WDepth = MAX_INPUTS * MAX_OUTPUTS;
	localparam int WAW    = (WDepth > 1) ? $clog2(WDepth) : 1;
	localparam int AIW    = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
	localparam int OIW    = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
	localparam int AccW   = 2 * DataW + $clog2(MAX_INPUTS + 1) + 1;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_START = 2'd1;
	localparam logic [1:0] ST_ISSUE = 2'd2;
	localparam logic [1:0] ST_WAIT  = 2'd3;

	logic [4:0]              n_inputs_q;
	logic [4:0]              n_outputs_q;
	logic                    act_mode_q;
	logic signed [DataW-1:0] bias_q;

	logic [1:0]              state_q;
	logic [AIW-1:0]          i_q;
	logic [OIW-1:0]          o_q;
	logic [WAW-1:0]          waddr_q;

	logic                    ni_zero;
	logic                    no_zero;
	logic [AIW-1:0]          last_i;
	logic [OIW-1:0]          last_o;
	logic                    req_fire;
	logic                    rd_en;

	logic [DataW-1:0]        w_mem [WDepth];
	logic [DataW-1:0]        act_mem [MAX_INPUTS];

	logic signed [DataW-1:0] act_rd_s1;
	logic signed [DataW-1:0] w_rd_s1;
	logic signed [DataW-1:0] act_use;
	mac_ctrl_t               ctrl_s1;
	logic                    wb_s1;
	logic [AIW-1:0]          ai_s1;

	logic                    res_valid;
	logic signed [DataW-1:0] res_value;

	rsp_word_t               rsp_word_q;
	logic                    rsp_valid_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_inputs_q  <= 5'd16;
			n_outputs_q <= 5'd16;
			act_mode_q  <= ACT_LINEAR;
			bias_q      <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_N_INPUTS:        n_inputs_q  <= cfg_data[4:0];
				CFG_N_OUTPUTS:       n_outputs_q <= cfg_data[4:0];
				CFG_ACTIVATION_MODE: act_mode_q  <= cfg_data[0];
				CFG_BIAS:            bias_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	// Effective counts, limited to the store sizes; a zero count still walks one slot.
	assign ni_zero = (n_inputs_q == 5'd0);
	assign no_zero = (n_outputs_q == 5'd0);

	always_comb begin
		if (ni_zero) begin
			last_i = '0;
		end else if (32'(n_inputs_q) > MAX_INPUTS) begin
			last_i = AIW'(MAX_INPUTS - 1);
		end else begin
			last_i = AIW'(n_inputs_q - 5'd1);
		end
		if (no_zero) begin
			last_o = '0;
		end else if (32'(n_outputs_q) > MAX_OUTPUTS) begin
			last_o = OIW'(MAX_OUTPUTS - 1);
		end else begin
			last_o = OIW'(n_outputs_q - 5'd1);
		end
	end

	assign req_ready = (state_q == ST_IDLE);
	assign req_fire  = req_valid && req_ready;
	assign rd_en     = (state_q == ST_ISSUE);

	// Run sequencer: one output row at a time, waiting for a free result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q     <= '0;
			o_q     <= '0;
			waddr_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req_fire && req_word.last) begin
						state_q <= ST_START;
						o_q     <= '0;
						waddr_q <= '0;
					end
				end
				ST_START: begin
					if (!rsp_valid_q) begin
						state_q <= ST_ISSUE;
						i_q     <= '0;
					end
				end
				ST_ISSUE: begin
					if (!ni_zero) begin
						waddr_q <= waddr_q + WAW'(1);
					end
					if (i_q == last_i) begin
						state_q <= ST_WAIT;
					end else begin
						i_q <= i_q + AIW'(1);
					end
				end
				ST_WAIT: begin
					if (res_valid) begin
						if (o_q == last_o) begin
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_START;
							o_q     <= o_q + OIW'(1);
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Weight memory: written by load words, read along the row during a run.
	always_ff @(posedge clk) begin
		if (req_fire && req_word.func == FUNC_WEIGHT && 32'(req_word.index) < WDepth) begin
			w_mem[WAW'(req_word.index)] <= req_word.value;
		end
		if (rd_en) begin
			w_rd_s1 <= w_mem[waddr_q];
		end
	end

	// Activation memory: load writes when idle, ReLU write-back on the first row.
	always_ff @(posedge clk) begin
		if (req_fire && req_word.func == FUNC_ACTIVATION
				&& 32'(req_word.index) < MAX_INPUTS) begin
			act_mem[AIW'(req_word.index)] <= req_word.value;
		end else if (ctrl_s1.valid && wb_s1 && act_rd_s1[DataW-1]) begin
			act_mem[ai_s1] <= '0;
		end
		if (rd_en) begin
			act_rd_s1 <= act_mem[i_q];
		end
	end

	// Control for the word coming out of the memories.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
			wb_s1   <= 1'b0;
		end else begin
			ctrl_s1.valid      <= rd_en;
			ctrl_s1.first      <= (i_q == '0);
			ctrl_s1.final_step <= (i_q == last_i);
			ctrl_s1.zero       <= ni_zero;
			wb_s1              <= (act_mode_q == ACT_RELU) && (o_q == '0) && !ni_zero;
		end
	end

	always_ff @(posedge clk) begin
		ai_s1 <= i_q;
	end

	// ReLU on use as well, so a row read before the write-back lands sees the same value.
	assign act_use = (act_mode_q == ACT_RELU && act_rd_s1[DataW-1]) ? '0 : act_rd_s1;

	dlf_mac #(
		.AccW(AccW)
	) u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl_s1),
		.act       (act_use),
		.wgt       (w_rd_s1),
		.bias      (bias_q),
		.res_valid (res_valid),
		.res_value (res_value)
	);

	// Result register; a run with no outputs still clamps but delivers nothing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_valid && !no_zero) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			rsp_word_q.out_index <= 4'(o_q);
			rsp_word_q.out_value <= res_value;
			rsp_word_q.out_last  <= (o_q == last_o);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_word  = rsp_word_q;

endmodule

/* hw/rtl/dlf_checker.sv */
module dlf_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_ready,
	input dlf_pkg::req_word_t  req_word,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input dlf_pkg::rsp_word_t  rsp_word
);
	import dlf_pkg::*;

	// A waiting result word holds until it is taken.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
		else $error("result word changed or dropped while stalled");

	// While a run still has outputs to deliver, no load word is taken.
	a_busy_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_word.out_last |-> !req_ready)
		else $error("load word taken in the middle of a run");

	// A word with last set starts a run at once.
	a_last_starts: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_word.last |=> !req_ready)
		else $error("block ready right after a last word");

	// Outputs of one run are spaced by at least a row walk.
	a_rsp_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_ready && !rsp_word.out_last |=> !rsp_valid)
		else $error("next output appeared without its row walk");

endmodule

bind dense_layer_forward_top dlf_checker u_dlf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.req_word  (req_word),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp_word  (rsp_word)
);

/* dv/dense_layer_forward_chk.sv */
module dense_layer_forward_chk (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	input  logic               req_ready,
	input  dlf_pkg::req_word_t req_word,
	input  logic               rsp_valid,
	input  logic               rsp_ready,
	input  dlf_pkg::rsp_word_t rsp_word,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	output int                 mismatch_count,
	output int                 results_owed
);
	import dlf_pkg::*;

	localparam int MaxIn  = 16;
	localparam int MaxOut = 16;

	// Own copy of the layer: weight rows, input activations and register values.
	logic signed [DataW-1:0] weight_mem [MaxIn*MaxOut];
	logic signed [DataW-1:0] act_mem [MaxIn];
	logic [4:0]              n_in_q;
	logic [4:0]              n_out_q;
	logic                    mode_q;
	logic signed [DataW-1:0] bias_q;

	// Neuron results worked out but not yet delivered, oldest first.
	rsp_word_t owed_neurons [$];

	initial begin
		mismatch_count = 0;
		results_owed   = 0;
	end

	// Clamp the activations if ReLU is selected, then form every neuron's
	// bias plus dot product, rounded half up and saturated to Q8.8.
	function automatic void compute_neurons();
		int        ni;
		int        no;
		longint    acc;
		longint    rounded;
		rsp_word_t r;
		ni = (n_in_q > MaxIn) ? MaxIn : n_in_q;
		no = (n_out_q > MaxOut) ? MaxOut : n_out_q;
		if (mode_q == ACT_RELU) begin
			for (int i = 0; i < ni; i++) begin
				if (act_mem[i] < 0) begin
					act_mem[i] = '0;
				end
			end
		end
		for (int o = 0; o < no; o++) begin
			acc = longint'(bias_q) * 256;
			for (int i = 0; i < ni; i++) begin
				acc += longint'(act_mem[i]) * longint'(weight_mem[o*ni+i]);
			end
			rounded = (acc + 128) >>> 8;
			if (rounded > 32767) begin
				rounded = 32767;
			end else if (rounded < -32768) begin
				rounded = -32768;
			end
			r.out_index = o[3:0];
			r.out_value = rounded[15:0];
			r.out_last  = (o == no - 1);
			owed_neurons.push_back(r);
		end
	endfunction

	// Follow register writes and load words, and check each delivered word.
	always @(posedge clk or negedge arst_n) begin
		rsp_word_t want;
		if (!arst_n) begin
			n_in_q  = 5'd16;
			n_out_q = 5'd16;
			mode_q  = ACT_LINEAR;
			bias_q  = '0;
			owed_neurons.delete();
			results_owed = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_N_INPUTS: begin
						n_in_q = cfg_data[4:0];
					end
					CFG_N_OUTPUTS: begin
						n_out_q = cfg_data[4:0];
					end
					CFG_ACTIVATION_MODE: begin
						mode_q = cfg_data[0];
					end
					CFG_BIAS: begin
						bias_q = cfg_data;
					end
				endcase
			end
			if (req_valid && req_ready) begin
				if (req_word.func == FUNC_WEIGHT) begin
					weight_mem[req_word.index] = req_word.value;
				end else if (req_word.index < MaxIn) begin
					act_mem[req_word.index[3:0]] = req_word.value;
				end
				if (req_word.last) begin
					compute_neurons();
				end
			end
			if (rsp_valid && rsp_ready) begin
				if (owed_neurons.size() == 0) begin
					$display("%0t: result word with none expected, got index %0d value %0d last %0d",
						$time, rsp_word.out_index, rsp_word.out_value, rsp_word.out_last);
					mismatch_count++;
				end else begin
					want = owed_neurons.pop_front();
					if (rsp_word.out_index !== want.out_index) begin
						$display("%0t: out_index expected %0d, got %0d",
							$time, want.out_index, rsp_word.out_index);
						mismatch_count++;
					end
					if (rsp_word.out_value !== want.out_value) begin
						$display("%0t: out_value of neuron %0d expected %0d, got %0d",
							$time, want.out_index, want.out_value, rsp_word.out_value);
						mismatch_count++;
					end
					if (rsp_word.out_last !== want.out_last) begin
						$display("%0t: out_last of neuron %0d expected %0d, got %0d",
							$time, want.out_index, want.out_last, rsp_word.out_last);
						mismatch_count++;
					end
				end
			end
			results_owed = owed_neurons.size();
		end
	end

endmodule

/* dv/dense_layer_forward_top_tb.sv */
module dense_layer_forward_top_tb;

	import dlf_pkg::*;

	localparam int MaxIn        = 16;
	localparam int RandomWords  = 260;
	localparam int SettleCycles = 40;
	localparam int TailCycles   = 100;
	localparam int HoldCycles   = 400;

	logic       clk;
	logic       arst_n;
	logic       req_valid;
	logic       req_ready;
	req_word_t  req_word;
	logic       rsp_valid;
	logic       rsp_ready;
	rsp_word_t  rsp_word;
	logic       cfg_we;
	logic [1:0] cfg_index;
	logic [15:0] cfg_data;

	int mismatch_count;
	int results_owed;

	// Which store entries hold a written value, so that no run reads a blank one.
	bit weights_loaded [256];
	bit acts_loaded [MaxIn];

	int cur_ni;
	int cur_no;
	int random_items;
	int hold_left;
	int holds_done;
	bit quiet;
	bit in_random;

	dense_layer_forward_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_word  (req_word),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_word  (rsp_word),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	dense_layer_forward_chk i_chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req_valid),
		.req_ready      (req_ready),
		.req_word       (req_word),
		.rsp_valid      (rsp_valid),
		.rsp_ready      (rsp_ready),
		.rsp_word       (rsp_word),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.mismatch_count (mismatch_count),
		.results_owed   (results_owed)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#3000000;
		$display("*** FAILED ***");
		$finish;
	end

	function automatic req_word_t load_word(logic f, int idx, logic [15:0] v, logic lst);
		req_word_t w;
		w.func  = f;
		w.index = idx[7:0];
		w.value = v;
		w.last  = lst;
		return w;
	endfunction

	// Q8.8 values: full-range noise half the time, with small values and the extremes mixed in.
	function automatic logic [15:0] q88_value();
		int          sel;
		logic [15:0] v;
		sel = $urandom_range(9);
		case (sel)
			0: v = 16'h7FFF;
			1: v = 16'h8000;
			2, 3, 4: begin
				v = 16'($urandom_range(1023));
				v = v - 16'd512;
			end
			default: v = 16'($urandom);
		endcase
		return v;
	endfunction

	// A stray word: any weight address, or an activation
	// index that is usually beyond the store and so dropped by the block.
	function automatic req_word_t stray_word();
		if ($urandom_range(1)) begin
			return load_word(FUNC_WEIGHT, $urandom_range(255), q88_value(), 1'b0);
		end
		return load_word(FUNC_ACTIVATION, $urandom_range(255), q88_value(), 1'b0);
	endfunction

	// Offer one load word from a falling edge and return at the falling edge
	// after it has been taken.
	task automatic send_word(input req_word_t w);
		while (!quiet && $urandom_range(99) < 32) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req_word  <= w;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		if (w.func == FUNC_WEIGHT) begin
			weights_loaded[w.index] = 1'b1;
		end else if (w.index < MaxIn) begin
			acts_loaded[w.index[3:0]] = 1'b1;
		end
		@(negedge clk);
	endtask

	// Stop offering words until every neuron result is in, then give the
	// block time to finish a run that produces nothing.
	task automatic drain_results();
		req_valid <= 1'b0;
		while (results_owed != 0) @(negedge clk);
		repeat (SettleCycles) @(negedge clk);
	endtask

	task automatic program_layer(input logic [4:0] ni, input logic [4:0] no,
		input logic mode, input logic [15:0] b);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_N_INPUTS;
		cfg_data  <= {11'd0, ni};
		@(negedge clk);
		cfg_index <= CFG_N_OUTPUTS;
		cfg_data  <= {11'd0, no};
		@(negedge clk);
		cfg_index <= CFG_ACTIVATION_MODE;
		cfg_data  <= {15'd0, mode};
		@(negedge clk);
		cfg_index <= CFG_BIAS;
		cfg_data  <= b;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		cur_ni = (ni > MaxIn) ? MaxIn : ni;
		cur_no = (no > 16) ? 16 : no;
	endtask

	// Mostly small layers; wide or tall ones and the zero counts now and then.
	task automatic random_layer();
		int         r;
		logic [4:0] ni;
		logic [4:0] no;
		r = $urandom_range(99);
		if (r < 60) begin
			ni = 5'($urandom_range(1, 4));
			no = 5'($urandom_range(1, 5));
		end else if (r < 70) begin
			ni = 5'($urandom_range(1, 2));
			no = 5'($urandom_range(8, 31));
		end else if (r < 78) begin
			ni = 5'($urandom_range(5, 31));
			no = 5'($urandom_range(1, 2));
		end else if (r < 84) begin
			ni = 5'd0;
			no = 5'($urandom_range(1, 4));
		end else if (r < 90) begin
			ni = 5'($urandom_range(1, 3));
			no = 5'd0;
		end else begin
			ni = 5'($urandom_range(1, 6));
			no = 5'($urandom_range(1, 3));
		end
		program_layer(ni, no, 1'($urandom_range(1)), q88_value());
	endtask

	// One pass: every entry the run will read that is still blank, some
	// rewrites and stray words, shuffled, with last on the final word.
	task automatic random_pass();
		req_word_t batch [$];
		req_word_t tmp;
		int        k;
		int        j;
		int        n_stray;
		for (k = 0; k < cur_ni; k++) begin
			if (!acts_loaded[k] || $urandom_range(3) == 0) begin
				batch.push_back(load_word(FUNC_ACTIVATION, k, q88_value(), 1'b0));
			end
		end
		for (k = 0; k < cur_ni * cur_no; k++) begin
			if (!weights_loaded[k] || $urandom_range(7) == 0) begin
				batch.push_back(load_word(FUNC_WEIGHT, k, q88_value(), 1'b0));
			end
		end
		n_stray = $urandom_range(2) + batch.size() / 5;
		for (k = 0; k < n_stray; k++) begin
			batch.push_back(stray_word());
		end
		if (batch.size() == 0) begin
			batch.push_back(stray_word());
		end
		for (k = batch.size() - 1; k > 0; k--) begin
			j        = $urandom_range(k);
			tmp      = batch[k];
			batch[k] = batch[j];
			batch[j] = tmp;
		end
		batch[batch.size() - 1].last = 1'b1;
		for (k = 0; k < batch.size(); k++) begin
			quiet = (random_items >= 100 && random_items < 160);
			if (batch[k].func == FUNC_WEIGHT || batch[k].index < MaxIn) begin
				random_items++;
			end
			send_word(batch[k]);
		end
	endtask

	// Result side: random stalls, a calm stretch, and a couple of long
	// hold-offs taken while the block is busy and a word is waiting at its input.
	initial begin
		rsp_ready  = 1'b0;
		hold_left  = 0;
		holds_done = 0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				rsp_ready <= 1'b0;
			end else if (in_random && holds_done < 2 && results_owed >= 4 &&
				req_valid && !req_ready) begin
				holds_done++;
				hold_left = HoldCycles - 1;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= quiet || ($urandom_range(99) >= 32);
			end
		end
	end

	initial begin
		arst_n       = 1'b0;
		req_valid    = 1'b0;
		req_word     = '0;
		cfg_we       = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		quiet        = 1'b0;
		in_random    = 1'b0;
		random_items = 0;
		cur_ni       = 16;
		cur_no       = 16;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Full-scale operands: both saturation limits, then a sign change.
		program_layer(5'd2, 5'd2, ACT_LINEAR, 16'h0000);
		send_word(load_word(FUNC_WEIGHT, 0, 16'h7FFF, 1'b0));
		send_word(load_word(FUNC_WEIGHT, 1, 16'h7FFF, 1'b0));
		send_word(load_word(FUNC_WEIGHT, 2, 16'h8000, 1'b0));
		send_word(load_word(FUNC_WEIGHT, 3, 16'h8000, 1'b0));
		send_word(load_word(FUNC_ACTIVATION, 0, 16'h7FFF, 1'b0));
		send_word(load_word(FUNC_ACTIVATION, 1, 16'h7FFF, 1'b1));
		send_word(load_word(FUNC_ACTIVATION, 1, 16'h8000, 1'b1));
		drain_results();

		// Exact halves round upwards on both signs; last on a weight word; last
		// on an activation word whose index is beyond the store.
		program_layer(5'd1, 5'd1, ACT_LINEAR, 16'h0000);
		send_word(load_word(FUNC_WEIGHT, 0, 16'h0080, 1'b0));
		send_word(load_word(FUNC_ACTIVATION, 0, 16'h0001, 1'b1));
		send_word(load_word(FUNC_ACTIVATION, 0, 16'hFFFF, 1'b1));
		send_word(load_word(FUNC_WEIGHT, 0, 16'h0100, 1'b1));
		send_word(load_word(FUNC_ACTIVATION, 255, 16'h1234, 1'b1));
		drain_results();

		// ReLU clears a negative input, leaving the largest bias alone.
		program_layer(5'd1, 5'd2, ACT_RELU, 16'h7FFF);
		send_word(load_word(FUNC_WEIGHT, 1, 16'h0100, 1'b0));
		send_word(load_word(FUNC_ACTIVATION, 0, 16'h8000, 1'b1));
		send_word(load_word(FUNC_ACTIVATION, 0, 16'h7FFF, 1'b1));
		drain_results();

		// No inputs gives the most negative bias alone; no outputs gives nothing.
		program_layer(5'd0, 5'd2, ACT_LINEAR, 16'h8000);
		send_word(load_word(FUNC_WEIGHT, 5, 16'h5555, 1'b1));
		drain_results();
		program_layer(5'd1, 5'd0, ACT_RELU, 16'h0001);
		send_word(load_word(FUNC_ACTIVATION, 0, 16'hFFFF, 1'b1));
		drain_results();

		// Random passes, changing the layer shape between some of them.
		in_random = 1'b1;
		random_layer();
		while (random_items < RandomWords) begin
			random_pass();
			if ($urandom_range(2) == 0) begin
				drain_results();
				random_layer();
			end else if ($urandom_range(5) == 0) begin
				drain_results();
			end
		end
		quiet = 1'b0;

		drain_results();
		repeat (TailCycles) @(negedge clk);
		if (mismatch_count == 0 && results_owed == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

/* dense_layer_forward_top.f */
hw/rtl/dlf_pkg.sv
hw/rtl/dlf_mac.sv
hw/rtl/dense_layer_forward_top.sv
hw/rtl/dlf_checker.sv
dv/dense_layer_forward_chk.sv
dv/dense_layer_forward_top_tb.sv
